@@ rtl/zero_run_stream_decompressor_assert.svh @@
// Assertion macros used by the decoder of the zero-run stream decompressor.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef ZERO_RUN_STREAM_DECOMPRESSOR_ASSERT_SVH
`define ZERO_RUN_STREAM_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication.
`define ZRSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zrsd assertion failed");

// Next-cycle implication.
`define ZRSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zrsd assertion failed");

`endif

@@ rtl/zrsd_pkg.sv @@
package zrsd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 32;
  localparam int IDX_W  = 2;

  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  // Index of the last byte of a 16-bit and of a 32-bit length word.
  localparam logic [IDX_W-1:0] IDX_LAST16 = 2'd1;
  localparam logic [IDX_W-1:0] IDX_LAST32 = 2'd3;

  typedef struct packed {
    logic              is_zero_run;
    logic [BYTE_W-1:0] literal;
    logic [LEN_W-1:0]  run_length;
  } zrsd_result_t;

endpackage

@@ rtl/zrsd_in_stage.sv @@
module zrsd_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [zrsd_pkg::BYTE_W-1:0] in_byte,
  input  logic                       s1_adv,
  output logic                       s1_valid,
  output logic [zrsd_pkg::BYTE_W-1:0] s1_byte
);
  import zrsd_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              accept;

  // The register can take a byte when it is empty or drains this cycle.
  assign in_stall = valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (s1_adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

@@ rtl/zrsd_decoder.sv @@
module zrsd_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [zrsd_pkg::BYTE_W-1:0] byte_in,
  output logic                       res_valid,
  output zrsd_pkg::zrsd_result_t     res
);
  import zrsd_pkg::*;

  `include "zero_run_stream_decompressor_assert.svh"

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN8,
    PH_LEN16,
    PH_LEN32,
    PH_DATA
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               izr_r, izr_nxt;
  logic [LEN_W-1:0]   remaining_r, remaining_nxt;
  logic [LEN_W-1:0]   acc_r, acc_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               fin;
  logic [LEN_W-1:0]   fin_len;
  logic               fin_izr;
  logic               emit_lit;
  logic               emit_run;
  logic [LEN_W-1:0]   acc_sh;

  assign acc_sh = {acc_r[LEN_W-BYTE_W-1:0], byte_in};

  always_comb begin
    phase_nxt     = phase_r;
    izr_nxt       = izr_r;
    remaining_nxt = remaining_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    fin           = 1'b0;
    fin_len       = '0;
    fin_izr       = izr_r;
    emit_lit      = 1'b0;
    emit_run      = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        izr_nxt   = 1'b0;
        phase_nxt = PH_LEN8;
        acc_nxt   = '0;
        idx_nxt   = '0;
      end
      PH_LEN8: begin
        if (byte_in != ZERO_BYTE) begin
          fin     = 1'b1;
          fin_len = LEN_W'(byte_in);
        end else begin
          phase_nxt = PH_LEN16;
          acc_nxt   = '0;
          idx_nxt   = '0;
        end
      end
      PH_LEN16: begin
        acc_nxt = acc_sh;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_LAST16) begin
          if (acc_sh != '0) begin
            fin     = 1'b1;
            fin_len = acc_sh;
          end else begin
            // A zero 16-bit word escapes to a 32-bit length.
            phase_nxt = PH_LEN32;
            acc_nxt   = '0;
            idx_nxt   = '0;
          end
        end
      end
      PH_LEN32: begin
        acc_nxt = acc_sh;
        if (idx_r == IDX_LAST32) begin
          fin     = 1'b1;
          fin_len = acc_sh;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      PH_DATA: begin
        if (remaining_r != '0) begin
          emit_lit      = 1'b1;
          remaining_nxt = remaining_r - LEN_W'(1);
          if (remaining_r == LEN_W'(1)) begin
            izr_nxt   = 1'b1;
            phase_nxt = PH_LEN8;
            acc_nxt   = '0;
            idx_nxt   = '0;
          end
        end else begin
          // An empty chunk phase treats the byte as the first byte of a run length.
          izr_nxt = 1'b1;
          fin_izr = 1'b1;
          if (byte_in != ZERO_BYTE) begin
            fin     = 1'b1;
            fin_len = LEN_W'(byte_in);
          end else begin
            phase_nxt = PH_LEN16;
            acc_nxt   = '0;
            idx_nxt   = '0;
          end
        end
      end
      default: begin
        // Unused codes take the byte as the first byte of a length.
        if (byte_in != ZERO_BYTE) begin
          fin     = 1'b1;
          fin_len = LEN_W'(byte_in);
        end else begin
          phase_nxt = PH_LEN16;
          acc_nxt   = '0;
          idx_nxt   = '0;
        end
      end
    endcase

    // A completed length either opens a chunk or closes a zero run; a zero chunk length leads to a run length.
    if (fin) begin
      phase_nxt = PH_LEN8;
      acc_nxt   = '0;
      idx_nxt   = '0;
      if (!fin_izr) begin
        if (fin_len == '0) begin
          izr_nxt = 1'b1;
        end else begin
          remaining_nxt = fin_len;
          phase_nxt     = PH_DATA;
        end
      end else begin
        izr_nxt  = 1'b0;
        emit_run = (fin_len != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      izr_r       <= 1'b0;
      remaining_r <= '0;
      acc_r       <= '0;
      idx_r       <= '0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      izr_r       <= izr_nxt;
      remaining_r <= remaining_nxt;
      acc_r       <= acc_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign res_valid        = adv && (emit_lit || emit_run);
  assign res.is_zero_run  = !emit_lit;
  assign res.literal      = emit_lit ? byte_in : ZERO_BYTE;
  assign res.run_length   = emit_lit ? LEN_W'(1) : fin_len;

  `ZRSD_ASSERT_IMP(a_run_nonzero, res_valid && res.is_zero_run, res.run_length != '0)
  `ZRSD_ASSERT_IMP(a_data_has_bytes, phase_r == PH_DATA, remaining_r != '0)
  `ZRSD_ASSERT_IMP(a_len16_index, phase_r == PH_LEN16, idx_r[1] == 1'b0)
  `ZRSD_ASSERT_NXT(a_header_once, adv && phase_r == PH_HEADER,
                   phase_r == PH_LEN8 && !izr_r)

endmodule

@@ rtl/zrsd_out_stage.sv @@
module zrsd_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_valid,
  input  zrsd_pkg::zrsd_result_t      res,
  output logic                        ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_zero_run,
  output logic [zrsd_pkg::BYTE_W-1:0] out_literal,
  output logic [zrsd_pkg::LEN_W-1:0]  out_run_length
);
  import zrsd_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  zrsd_result_t res_r;

  // The result register is free when empty or when its transfer completes now.
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_is_zero_run = res_r.is_zero_run;
  assign out_literal     = res_r.literal;
  assign out_run_length  = res_r.run_length;

endmodule

@@ rtl/zero_run_stream_decompressor.sv @@
// Channel   Direction  Ports                                         Payload
// input     in         in_valid, in_stall, in_byte                   one compressed byte
// result    out        out_valid, out_stall, out_is_zero_run,        literal byte or
//                      out_literal, out_run_length                   zero-run descriptor
//
// One byte is taken per cycle while in_stall is low; its result, if any, goes through the
// input register and then the result register before it is on the result ports.
// The length/chunk state update is one short step between the two registers, so bytes
// stream at one per cycle with no gaps while the result channel does not stall.
// Reset is synchronous and active low; after it the next byte is taken as the header.
// A stall on the result channel holds the result register and, in the same cycle,
// stalls the input channel only if the input register is also full.
module zero_run_stream_decompressor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [zrsd_pkg::BYTE_W-1:0] in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_zero_run,
  output logic [zrsd_pkg::BYTE_W-1:0] out_literal,
  output logic [zrsd_pkg::LEN_W-1:0]  out_run_length
);
  import zrsd_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_adv;
  logic              out_ready;
  logic              res_valid;
  zrsd_result_t      res;

  // A registered byte moves on whenever the result register can take whatever it
  // produces. Bytes that produce nothing still advance the decoder state.
  assign s1_adv = s1_valid && out_ready;

  zrsd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .s1_adv   (s1_adv),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  // Header skip, length assembly and chunk counting live here.
  zrsd_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .byte_in   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // The result register holds one transfer for the downstream side.
  zrsd_out_stage u_out_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .ready           (out_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_zero_run (out_is_zero_run),
    .out_literal     (out_literal),
    .out_run_length  (out_run_length)
  );

endmodule
